@@ design/tcphc_pkg.sv @@
// Shared types, codes and the flag classifier for the TCP header checker.
package tcphc_pkg;

  localparam int unsigned HDR_MIN_BYTES = 20;

  localparam logic [2:0] HS_OK        = 3'd0;
  localparam logic [2:0] HS_SHORT_SEG = 3'd1;
  localparam logic [2:0] HS_SHORT_OFF = 3'd2;
  localparam logic [2:0] HS_HDR_LONG  = 3'd3;
  localparam logic [2:0] HS_URGENT    = 3'd4;

  localparam logic [2:0] OS_NONE     = 3'd0;
  localparam logic [2:0] OS_OVERRUN  = 3'd1;
  localparam logic [2:0] OS_SHORT_LEN = 3'd2;
  localparam logic [2:0] OS_BAD_LEN  = 3'd3;
  localparam logic [2:0] OS_UNKNOWN  = 3'd4;

  localparam logic [2:0] FC_SYN     = 3'd0;
  localparam logic [2:0] FC_SYNACK  = 3'd1;
  localparam logic [2:0] FC_FIN     = 3'd2;
  localparam logic [2:0] FC_DATA    = 3'd3;
  localparam logic [2:0] FC_ACK     = 3'd4;
  localparam logic [2:0] FC_RST     = 3'd5;
  localparam logic [2:0] FC_OTHER   = 3'd6;
  localparam logic [2:0] FC_UNEXPECTED = 3'd7;

  localparam logic [7:0] TAG_END    = 8'd0;
  localparam logic [7:0] TAG_NOP    = 8'd1;
  localparam logic [7:0] TAG_MSS    = 8'd2;
  localparam logic [7:0] TAG_WSCALE = 8'd3;
  localparam logic [7:0] TAG_SACKOK = 8'd4;
  localparam logic [7:0] TAG_SACK   = 8'd5;
  localparam logic [7:0] TAG_TSTAMP = 8'd8;

  localparam logic [7:0] LEN_MSS    = 8'd4;
  localparam logic [7:0] LEN_SACKOK = 8'd2;

  localparam logic [7:0] FLAG_FIN = 8'h01;
  localparam logic [7:0] FLAG_SYN = 8'h02;
  localparam logic [7:0] FLAG_RST = 8'h04;
  localparam logic [7:0] FLAG_PSH = 8'h08;
  localparam logic [7:0] FLAG_ACK = 8'h10;
  localparam logic [7:0] FLAG_URG = 8'h20;
  localparam logic [7:0] FLAG_ECE = 8'h40;

  typedef enum logic [2:0] {
    OPT_TAG  = 3'b001,
    OPT_LEN  = 3'b010,
    OPT_BODY = 3'b100
  } opt_phase_t;

  // Everything the back end needs about one finished segment.
  typedef struct packed {
    logic [15:0] seg_len;
    logic [15:0] from_port;
    logic [15:0] to_port;
    logic [31:0] seq_num;
    logic [31:0] ack_num;
    logic [3:0]  data_off;
    logic [7:0]  flags;
    logic [15:0] window;
    logic [15:0] urgent;
    logic [2:0]  opt_problem;
    logic [15:0] payload_cnt;
  } seg_rec_t;

  typedef struct packed {
    logic [2:0]  header_status;
    logic [2:0]  option_status;
    logic [2:0]  flag_class;
    logic [15:0] source_port;
    logic [15:0] destination_port;
    logic [31:0] sequence_number;
    logic [31:0] acknowledge_number;
    logic [5:0]  header_bytes;
    logic [7:0]  flag_bits;
    logic [15:0] window_size;
    logic [15:0] payload_bytes;
  } result_t;

  function automatic logic [2:0] classify_flags(input logic [7:0] flags,
                                                input logic has_payload);
    logic [2:0] cls;
    unique case (flags[5:0])
      6'(FLAG_SYN):                          cls = FC_SYN;
      6'(FLAG_SYN | FLAG_ACK):               cls = FC_SYNACK;
      6'(FLAG_FIN),
      6'(FLAG_FIN | FLAG_ACK),
      6'(FLAG_FIN | FLAG_ACK | FLAG_PSH):    cls = FC_FIN;
      6'(FLAG_ACK),
      6'(FLAG_ACK | FLAG_PSH):               cls = has_payload ? FC_DATA : FC_ACK;
      6'(FLAG_RST),
      6'(FLAG_RST | FLAG_ACK):               cls = FC_RST;
      6'(FLAG_RST | FLAG_ACK | FLAG_FIN),
      6'(FLAG_RST | FLAG_ACK | FLAG_PSH):    cls = FC_OTHER;
      // The ECE bit sits outside the low six bits, but an ECE plus ACK byte
      // already matches the ACK case above, so this whole-byte match never sees it.
      default: cls = (flags == (FLAG_ECE | FLAG_ACK)) ? FC_OTHER : FC_UNEXPECTED;
    endcase
    return cls;
  endfunction

endpackage

@@ design/tcp_header_option_checker.sv @@
// Top level of the TCP header and option checker.
//
// Segment bytes enter as words on the in_ channel, header first, one per
// cycle: a word is taken when in_push is high and in_full is low, and
// in_last_byte marks the final byte of a segment. One result word per
// segment comes out on the out_ channel: it is valid while out_empty is
// low and is taken when out_pop is high.
// The front end takes each byte as it arrives and never waits on a byte.
// After the last byte the segment summary is registered in a two-entry
// queue, and the back end's checked result is registered in its result
// queue before it shows on the out_ channel. Back-to-back segments, even
// one-byte ones, run at one word per cycle while in_full stays low.
// If the receiver stops popping, the two-entry result queue and then the
// two-entry segment queue fill; in_full rises only when the segment queue
// is full, so up to four results wait before input stalls.
// Reset (rst_n low, synchronous) empties both queues and clears the byte
// counter, the held header and the option walker.
module tcp_header_option_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [2:0]  out_header_status,
  output logic [2:0]  out_option_status,
  output logic [2:0]  out_flag_class,
  output logic [15:0] out_source_port,
  output logic [15:0] out_destination_port,
  output logic [31:0] out_sequence_number,
  output logic [31:0] out_acknowledge_number,
  output logic [5:0]  out_header_bytes,
  output logic [7:0]  out_flag_bits,
  output logic [15:0] out_window_size,
  output logic [15:0] out_payload_bytes
);
  import tcphc_pkg::*;

  logic     byte_acc;
  logic     rec_push;
  seg_rec_t rec_in;
  logic     q_full;
  logic     q_empty;
  logic     q_pop;
  seg_rec_t q_head;
  result_t  res;

  assign in_full  = q_full;
  assign byte_acc = in_push && !in_full;

  tcphc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .byte_valid (byte_acc),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .rec_push   (rec_push),
    .rec        (rec_in)
  );

  tcphc_seg_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (rec_push),
    .push_rec (rec_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (q_head)
  );

  tcphc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_empty (q_empty),
    .rec       (q_head),
    .rec_pop   (q_pop),
    .res_empty (out_empty),
    .res_pop   (out_pop),
    .res       (res)
  );

  assign out_header_status      = res.header_status;
  assign out_option_status      = res.option_status;
  assign out_flag_class         = res.flag_class;
  assign out_source_port        = res.source_port;
  assign out_destination_port   = res.destination_port;
  assign out_sequence_number    = res.sequence_number;
  assign out_acknowledge_number = res.acknowledge_number;
  assign out_header_bytes       = res.header_bytes;
  assign out_flag_bits          = res.flag_bits;
  assign out_window_size        = res.window_size;
  assign out_payload_bytes      = res.payload_bytes;

endmodule

@@ design/tcphc_front.sv @@
// Front end: takes segment bytes, captures the fixed header, walks the options.
module tcphc_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_valid,
  input  logic [7:0]          data_byte,
  input  logic                last_byte,
  output logic                rec_push,
  output tcphc_pkg::seg_rec_t rec
);
  import tcphc_pkg::*;

  logic [15:0] pos_r, pos_nxt;
  logic [7:0]  hdr_r [HDR_MIN_BYTES];
  logic [7:0]  hdr_nxt [HDR_MIN_BYTES];
  opt_phase_t  phase_r, phase_nxt;
  logic [7:0]  tag_r, tag_nxt;
  logic [7:0]  rem_r, rem_nxt;
  logic [2:0]  prob_r, prob_nxt;
  logic        stop_r, stop_nxt;
  logic [15:0] pay_r, pay_nxt;

  logic [5:0]  opt_hdr;
  logic [5:0]  pos6;
  logic        in_fixed;
  logic        in_opts;
  logic        tag_overrun;
  logic        len_overrun;
  logic [9:0]  opt_end;
  logic [2:0]  len_code;

  // Header length as seen while bytes 20 and up arrive; byte 12 is already held.
  assign opt_hdr  = {hdr_r[12][7:4], 2'b00};
  assign pos6     = pos_r[5:0];
  assign in_fixed = pos_r < 16'(HDR_MIN_BYTES);
  assign in_opts  = !in_fixed && (pos_r < {10'd0, opt_hdr});

  assign tag_overrun = ({1'b0, pos6} + 7'd1) >= {1'b0, opt_hdr};
  assign opt_end     = {4'd0, pos6} + {2'd0, data_byte} - 10'd1;
  assign len_overrun = opt_end > {4'd0, opt_hdr};

  always_comb begin
    priority case (tag_r)
      TAG_MSS:    len_code = (data_byte != LEN_MSS) ? OS_BAD_LEN : OS_NONE;
      TAG_SACKOK: len_code = (data_byte != LEN_SACKOK) ? OS_BAD_LEN : OS_NONE;
      TAG_WSCALE, TAG_SACK, TAG_TSTAMP: len_code = OS_NONE;
      default:    len_code = OS_UNKNOWN;
    endcase
  end

  always_comb begin
    pos_nxt   = pos_r;
    hdr_nxt   = hdr_r;
    phase_nxt = phase_r;
    tag_nxt   = tag_r;
    rem_nxt   = rem_r;
    prob_nxt  = prob_r;
    stop_nxt  = stop_r;
    pay_nxt   = pay_r;
    rec_push  = 1'b0;

    if (byte_valid) begin
      if (in_fixed) begin
        for (int k = 0; k < HDR_MIN_BYTES; k++) begin
          if (pos_r == 16'(k)) begin
            hdr_nxt[k] = data_byte;
          end
        end
      end else if (in_opts) begin
        if (!stop_r) begin
          unique case (phase_r)
            OPT_TAG: begin
              if (data_byte == TAG_END) begin
                stop_nxt = 1'b1;
              end else if (data_byte != TAG_NOP) begin
                if (tag_overrun) begin
                  if (prob_r == OS_NONE) prob_nxt = OS_OVERRUN;
                  stop_nxt = 1'b1;
                end else begin
                  tag_nxt   = data_byte;
                  phase_nxt = OPT_LEN;
                end
              end
            end
            OPT_LEN: begin
              if (data_byte < 8'd2) begin
                if (prob_r == OS_NONE) prob_nxt = OS_SHORT_LEN;
                stop_nxt = 1'b1;
              end else if (len_overrun) begin
                if (prob_r == OS_NONE) prob_nxt = OS_OVERRUN;
                stop_nxt = 1'b1;
              end else begin
                if (prob_r == OS_NONE) prob_nxt = len_code;
                rem_nxt   = data_byte - 8'd2;
                phase_nxt = (data_byte == 8'd2) ? OPT_TAG : OPT_BODY;
              end
            end
            OPT_BODY: begin
              rem_nxt = rem_r - 8'd1;
              if (rem_r == 8'd1) phase_nxt = OPT_TAG;
            end
            default: phase_nxt = OPT_TAG;
          endcase
        end
      end else if (pay_r != 16'hFFFF) begin
        pay_nxt = pay_r + 16'd1;
      end

      if (pos_r != 16'hFFFF) pos_nxt = pos_r + 16'd1;

      if (last_byte) begin
        rec_push = 1'b1;
        // A new segment starts from a clean slate after its last word.
        pos_nxt   = '0;
        phase_nxt = OPT_TAG;
        tag_nxt   = '0;
        rem_nxt   = '0;
        prob_nxt  = OS_NONE;
        stop_nxt  = 1'b0;
        pay_nxt   = '0;
        for (int k = 0; k < HDR_MIN_BYTES; k++) begin
          hdr_nxt[k] = '0;
        end
      end
    end
  end

  // Problem code after the walker step, without the end-of-segment clear.
  function automatic logic [2:0] prob_nxt_walk();
    logic [2:0] p;
    p = prob_r;
    if (p == OS_NONE) begin
      unique case (phase_r)
        OPT_TAG: begin
          if (data_byte != TAG_END && data_byte != TAG_NOP && tag_overrun) p = OS_OVERRUN;
        end
        OPT_LEN: begin
          if (data_byte < 8'd2)  p = OS_SHORT_LEN;
          else if (len_overrun)  p = OS_OVERRUN;
          else                   p = len_code;
        end
        OPT_BODY: p = prob_r;
        default:  p = prob_r;
      endcase
    end
    return p;
  endfunction

  // The record carries the state as updated by the last word itself.
  always_comb begin
    logic [7:0] hb [HDR_MIN_BYTES];
    hb = hdr_r;
    for (int k = 0; k < HDR_MIN_BYTES; k++) begin
      if (in_fixed && pos_r == 16'(k)) hb[k] = data_byte;
    end
    rec.seg_len     = (pos_r != 16'hFFFF) ? pos_r + 16'd1 : pos_r;
    rec.from_port   = {hb[0], hb[1]};
    rec.to_port     = {hb[2], hb[3]};
    rec.seq_num     = {hb[4], hb[5], hb[6], hb[7]};
    rec.ack_num     = {hb[8], hb[9], hb[10], hb[11]};
    rec.data_off    = hb[12][7:4];
    rec.flags       = hb[13];
    rec.window      = {hb[14], hb[15]};
    rec.urgent      = {hb[18], hb[19]};
    rec.opt_problem = prob_nxt;
    rec.payload_cnt = pay_nxt;
    if (last_byte) begin
      rec.opt_problem = (in_opts && !stop_r) ? prob_nxt_walk() : prob_r;
      rec.payload_cnt = (!in_fixed && !in_opts && pay_r != 16'hFFFF) ?
                        pay_r + 16'd1 : pay_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= OPT_TAG;
      tag_r   <= '0;
      rem_r   <= '0;
      prob_r  <= OS_NONE;
      stop_r  <= 1'b0;
      pay_r   <= '0;
      for (int k = 0; k < HDR_MIN_BYTES; k++) begin
        hdr_r[k] <= '0;
      end
    end else begin
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      phase_r <= phase_nxt;
      tag_r   <= tag_nxt;
      rem_r   <= rem_nxt;
      prob_r  <= prob_nxt;
      stop_r  <= stop_nxt;
      pay_r   <= pay_nxt;
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    byte_valid && last_byte |=> pos_r == '0 && prob_r == OS_NONE && !stop_r)
    else $error("front state not cleared after last word");

  a_first_problem_kept: assert property (@(posedge clk) disable iff (!rst_n)
    prob_r != OS_NONE && !(byte_valid && last_byte) |=> prob_r == $past(prob_r))
    else $error("first option problem overwritten");

  a_body_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == OPT_BODY |-> rem_r != '0)
    else $error("option body phase with nothing left to skip");

endmodule

@@ design/tcphc_seg_queue.sv @@
// Two-entry queue of segment records between the front and back ends.
module tcphc_seg_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tcphc_pkg::seg_rec_t push_rec,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output tcphc_pkg::seg_rec_t head
);
  import tcphc_pkg::*;

  seg_rec_t   mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       do_push;
  logic       do_pop;

  assign full    = cnt_r == 2'd2;
  assign empty   = cnt_r == 2'd0;
  assign head    = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("segment queue count out of range");

  a_ptrs_track_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 || cnt_r == 2'd2) |-> wr_ptr_r == rd_ptr_r)
    else $error("segment queue pointers disagree with count");

endmodule

@@ design/tcphc_back.sv @@
// Back end: checks a finished segment and holds results until they are taken.
module tcphc_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                rec_empty,
  input  tcphc_pkg::seg_rec_t rec,
  output logic                rec_pop,
  output logic                res_empty,
  input  logic                res_pop,
  output tcphc_pkg::result_t  res
);
  import tcphc_pkg::*;

  result_t    mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       res_full;
  logic       do_out;

  logic [5:0] hdr_len;
  logic [2:0] hstat;
  result_t    calc;

  assign hdr_len = {rec.data_off, 2'b00};

  always_comb begin
    priority if (rec.seg_len < 16'(HDR_MIN_BYTES))            hstat = HS_SHORT_SEG;
    else if (hdr_len < 6'(HDR_MIN_BYTES))                     hstat = HS_SHORT_OFF;
    else if ({10'd0, hdr_len} > rec.seg_len)                  hstat = HS_HDR_LONG;
    else if ((rec.flags & FLAG_URG) != '0 && rec.urgent != '0) hstat = HS_URGENT;
    else                                                      hstat = HS_OK;
  end

  always_comb begin
    calc.header_status      = hstat;
    calc.option_status      = (hstat == HS_OK) ? rec.opt_problem : OS_NONE;
    calc.flag_class         = classify_flags(rec.flags,
                                hstat == HS_OK && rec.payload_cnt != '0);
    calc.source_port        = rec.from_port;
    calc.destination_port   = rec.to_port;
    calc.sequence_number    = rec.seq_num;
    calc.acknowledge_number = rec.ack_num;
    calc.header_bytes       = hdr_len;
    calc.flag_bits          = rec.flags;
    calc.window_size        = rec.window;
    calc.payload_bytes      = (hstat == HS_OK) ? rec.payload_cnt : '0;
  end

  assign res_full  = cnt_r == 2'd2;
  assign res_empty = cnt_r == 2'd0;
  assign res       = mem_r[rd_ptr_r];
  assign rec_pop   = !rec_empty && !res_full;
  assign do_out    = res_pop && !res_empty;

  always_comb begin
    wr_ptr_nxt = rec_pop ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_out ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, rec_pop} - {1'b0, do_out};
  end

  always_ff @(posedge clk) begin
    if (rec_pop) mem_r[wr_ptr_r] <= calc;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    res_full && !do_out |=> cnt_r == 2'd2)
    else $error("result queue changed level without a pop");

  a_ok_means_clean: assert property (@(posedge clk) disable iff (!rst_n)
    rec_pop && hstat != HS_OK |=> mem_r[$past(wr_ptr_r)].payload_bytes == '0)
    else $error("payload reported for a corrupt header");

endmodule

@@ bench/tcp_result_checker.sv @@
// Checker that predicts and compares the TCP header checker's result words.
module tcp_result_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  input  logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  input  logic        out_empty,
  input  logic        out_pop,
  input  logic [2:0]  out_header_status,
  input  logic [2:0]  out_option_status,
  input  logic [2:0]  out_flag_class,
  input  logic [15:0] out_source_port,
  input  logic [15:0] out_destination_port,
  input  logic [31:0] out_sequence_number,
  input  logic [31:0] out_acknowledge_number,
  input  logic [5:0]  out_header_bytes,
  input  logic [7:0]  out_flag_bits,
  input  logic [15:0] out_window_size,
  input  logic [15:0] out_payload_bytes,
  output int          fail_count,
  output int          pending_results
);
  import tcphc_pkg::*;

  localparam logic [7:0] FLAG_MASK   = 8'h3F;
  localparam logic [7:0] OPT_MIN_LEN = 8'd2;

  // Per-segment state of the predictor.
  logic [15:0] seen_count;
  logic [7:0]  hdr_q [0:19];
  opt_phase_t  walk_phase;
  logic [7:0]  walk_tag;
  logic [7:0]  walk_left;
  logic [2:0]  first_problem;
  logic        walk_done;
  logic [15:0] body_count;

  result_t expected_summaries [$];
  result_t oldest;
  int      mismatch_total;

  task automatic clear_segment();
    seen_count    = '0;
    for (int i = 0; i < HDR_MIN_BYTES; i++) hdr_q[i] = '0;
    walk_phase    = OPT_TAG;
    walk_tag      = '0;
    walk_left     = '0;
    first_problem = OS_NONE;
    walk_done     = 1'b0;
    body_count    = '0;
  endtask

  task automatic note_problem(input logic [2:0] code, input logic stop);
    if (first_problem == OS_NONE) first_problem = code;
    if (stop) walk_done = 1'b1;
  endtask

  task automatic walk_option(input int pos, input int hdr, input logic [7:0] b);
    if (walk_done) return;
    case (walk_phase)
      OPT_TAG: begin
        if (b == TAG_END) begin
          walk_done = 1'b1;
        end else if (b != TAG_NOP) begin
          // A tag on the final header byte leaves no room for its length.
          if (pos + 1 >= hdr) begin
            note_problem(OS_OVERRUN, 1'b1);
          end else begin
            walk_tag   = b;
            walk_phase = OPT_LEN;
          end
        end
      end
      OPT_LEN: begin
        if (b < OPT_MIN_LEN) begin
          note_problem(OS_SHORT_LEN, 1'b1);
        end else if (pos + 1 + int'(b) - 2 > hdr) begin
          note_problem(OS_OVERRUN, 1'b1);
        end else begin
          case (walk_tag)
            TAG_MSS:    if (b != LEN_MSS) note_problem(OS_BAD_LEN, 1'b0);
            TAG_SACKOK: if (b != LEN_SACKOK) note_problem(OS_BAD_LEN, 1'b0);
            TAG_WSCALE, TAG_SACK, TAG_TSTAMP: ;
            default:    note_problem(OS_UNKNOWN, 1'b0);
          endcase
          walk_left  = b - OPT_MIN_LEN;
          walk_phase = (walk_left != 0) ? OPT_BODY : OPT_TAG;
        end
      end
      default: begin
        walk_left = walk_left - 1'b1;
        if (walk_left == 0) walk_phase = OPT_TAG;
      end
    endcase
  endtask

  function automatic logic [2:0] class_of(input logic [7:0] flags, input logic with_data);
    logic [7:0] low;
    low = flags & FLAG_MASK;
    if (low == FLAG_SYN) return FC_SYN;
    if (low == (FLAG_SYN | FLAG_ACK)) return FC_SYNACK;
    if (low == FLAG_FIN || low == (FLAG_FIN | FLAG_ACK) ||
        low == (FLAG_FIN | FLAG_ACK | FLAG_PSH)) return FC_FIN;
    if (low == FLAG_ACK || low == (FLAG_ACK | FLAG_PSH))
      return with_data ? FC_DATA : FC_ACK;
    if (low == FLAG_RST || low == (FLAG_RST | FLAG_ACK)) return FC_RST;
    // The ECE plus ACK byte is compared whole, after the masked cases.
    if (low == (FLAG_RST | FLAG_ACK | FLAG_FIN) || low == (FLAG_RST | FLAG_ACK | FLAG_PSH) ||
        flags == (FLAG_ECE | FLAG_ACK)) return FC_OTHER;
    return FC_UNEXPECTED;
  endfunction

  task automatic absorb_segment_byte(input logic [7:0] b, input logic last);
    int         pos;
    int         hdr;
    int         len;
    logic [7:0] flags;
    logic [15:0] urgent;
    logic [2:0] hstat;
    result_t    r;
    pos = seen_count;
    hdr = int'(hdr_q[12][7:4]) * 4;
    if (pos < HDR_MIN_BYTES) hdr_q[pos] = b;
    else if (pos < hdr) walk_option(pos, hdr, b);
    else if (body_count != 16'hFFFF) body_count = body_count + 1'b1;
    if (seen_count != 16'hFFFF) seen_count = seen_count + 1'b1;
    if (last) begin
      len    = seen_count;
      hdr    = int'(hdr_q[12][7:4]) * 4;
      flags  = hdr_q[13];
      urgent = {hdr_q[18], hdr_q[19]};
      if (len < HDR_MIN_BYTES) hstat = HS_SHORT_SEG;
      else if (hdr < HDR_MIN_BYTES) hstat = HS_SHORT_OFF;
      else if (hdr > len) hstat = HS_HDR_LONG;
      else if ((flags & FLAG_URG) != 0 && urgent != 0) hstat = HS_URGENT;
      else hstat = HS_OK;
      r.header_status      = hstat;
      r.option_status      = (hstat == HS_OK) ? first_problem : OS_NONE;
      r.flag_class         = class_of(flags, hstat == HS_OK && body_count != 0);
      r.source_port        = {hdr_q[0], hdr_q[1]};
      r.destination_port   = {hdr_q[2], hdr_q[3]};
      r.sequence_number    = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
      r.acknowledge_number = {hdr_q[8], hdr_q[9], hdr_q[10], hdr_q[11]};
      r.header_bytes       = 6'(hdr);
      r.flag_bits          = flags;
      r.window_size        = {hdr_q[14], hdr_q[15]};
      r.payload_bytes      = (hstat == HS_OK) ? body_count : 16'd0;
      expected_summaries.push_back(r);
      clear_segment();
    end
  endtask

  task automatic compare_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
      mismatch_total++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_segment();
      expected_summaries.delete();
      mismatch_total = 0;
    end else begin
      if (!out_empty && out_pop) begin
        if (expected_summaries.size() == 0) begin
          $display("%0t: result word expected none actual header_status %0d",
                   $time, out_header_status);
          mismatch_total++;
        end else begin
          oldest = expected_summaries.pop_front();
          compare_field("header_status", oldest.header_status, out_header_status);
          compare_field("option_status", oldest.option_status, out_option_status);
          compare_field("flag_class", oldest.flag_class, out_flag_class);
          compare_field("source_port", oldest.source_port, out_source_port);
          compare_field("destination_port", oldest.destination_port,
                        out_destination_port);
          compare_field("sequence_number", oldest.sequence_number, out_sequence_number);
          compare_field("acknowledge_number", oldest.acknowledge_number,
                        out_acknowledge_number);
          compare_field("header_bytes", oldest.header_bytes, out_header_bytes);
          compare_field("flag_bits", oldest.flag_bits, out_flag_bits);
          compare_field("window_size", oldest.window_size, out_window_size);
          compare_field("payload_bytes", oldest.payload_bytes, out_payload_bytes);
        end
      end
      if (in_push && !in_full) absorb_segment_byte(in_data_byte, in_last_byte);
    end
    fail_count      = mismatch_total;
    pending_results = expected_summaries.size();
  end

endmodule

@@ bench/tb_top.sv @@
// Top of the TCP header checker bench: segment stimulus, result popping and verdict.
module tb_top;
  import tcphc_pkg::*;

  localparam logic [7:0] FLAG_CWR    = 8'h80;
  localparam int         LEN_WSCALE  = 3;
  localparam int         LEN_TSTAMP  = 10;
  localparam int         SACK_BLOCK  = 8;
  localparam int         FLAG_SETS   = 15;
  localparam int         RANDOM_BYTES = 1200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [2:0]  out_header_status;
  logic [2:0]  out_option_status;
  logic [2:0]  out_flag_class;
  logic [15:0] out_source_port;
  logic [15:0] out_destination_port;
  logic [31:0] out_sequence_number;
  logic [31:0] out_acknowledge_number;
  logic [5:0]  out_header_bytes;
  logic [7:0]  out_flag_bits;
  logic [15:0] out_window_size;
  logic [15:0] out_payload_bytes;
  int          fail_count;
  int          pending_results;

  logic [7:0] seg_q [$];
  int         burst_left = 0;
  int         random_bytes = 0;
  bit         hold_req = 1'b0;
  bit         hold_done = 1'b0;

  tcp_header_option_checker uut (.*);
  tcp_result_checker result_check (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The sender works in bursts; a gap may open before the first word of a burst.
  task automatic put_byte(input logic [7:0] b, input logic last, input bit allow_gap);
    if (allow_gap) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        if ($urandom_range(0, 3) != 0) begin
          in_push <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
      burst_left--;
    end
    in_push      <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  task automatic send_segment(input bit allow_gap);
    int n;
    n = seg_q.size();
    for (int i = 0; i < n; i++) put_byte(seg_q[i], i == n - 1, allow_gap);
  endtask

  // A negative fill gives random header bytes, otherwise every free byte is fill.
  task automatic start_segment(input logic [3:0] offw, input logic [7:0] flags,
                               input logic [15:0] urg, input int fill);
    logic [7:0] v;
    seg_q.delete();
    for (int i = 0; i < HDR_MIN_BYTES; i++) begin
      v = (fill < 0) ? 8'($urandom) : 8'(fill);
      case (i)
        12: v = {offw, v[3:0]};
        13: v = flags;
        18: v = urg[15:8];
        19: v = urg[7:0];
        default: ;
      endcase
      seg_q.push_back(v);
    end
  endtask

  task automatic add_payload(input int n);
    repeat (n) seg_q.push_back(8'($urandom));
  endtask

  task automatic add_opt(input logic [7:0] tag, input int len);
    seg_q.push_back(tag);
    seg_q.push_back(8'(len));
    if (len > 2) add_payload(len - 2);
  endtask

  task automatic truncate_segment(input int n);
    while (seg_q.size() > n) void'(seg_q.pop_back());
  endtask

  // Fills the option area; with_errors mixes in malformed options.
  task automatic fill_options(input int room, input bit with_errors);
    int         kind;
    int         len;
    logic [7:0] tag;
    while (room > 0) begin
      kind = $urandom_range(0, with_errors ? 11 : 7);
      tag  = TAG_NOP;
      len  = 1;
      case (kind)
        1: begin tag = TAG_MSS; len = LEN_MSS; end
        2: begin tag = TAG_WSCALE; len = LEN_WSCALE; end
        3: begin tag = TAG_SACKOK; len = LEN_SACKOK; end
        4: begin tag = TAG_TSTAMP; len = LEN_TSTAMP; end
        5: begin tag = TAG_SACK; len = 2 + SACK_BLOCK * $urandom_range(1, 4); end
        6: begin tag = TAG_END; len = 0; end
        8: begin
          tag = $urandom_range(0, 1) ? TAG_MSS : TAG_SACKOK;
          len = $urandom_range(2, 6);
        end
        9: begin
          tag = 8'($urandom_range(6, 255));
          if (tag == TAG_TSTAMP) tag = tag + 1'b1;
          len = $urandom_range(2, 12);
        end
        10: begin tag = 8'($urandom_range(2, 255)); len = -($urandom_range(0, 1)); end
        11: begin tag = 8'($urandom_range(2, 255)); len = -(room + $urandom_range(1, 20)); end
        default: ;
      endcase
      if (tag == TAG_END) begin
        // Everything after the end tag is left unchecked by the walk.
        seg_q.push_back(TAG_END);
        add_payload(room - 1);
        room = 0;
      end else if (len <= 0) begin
        // Raw tag and length byte: a length below two or one that runs past the header.
        seg_q.push_back(tag);
        if (room > 1) seg_q.push_back(8'(-len));
        room -= 2;
      end else if (tag == TAG_NOP || len > room) begin
        seg_q.push_back(TAG_NOP);
        room--;
      end else begin
        add_opt(tag, len);
        room -= len;
      end
    end
  endtask

  function automatic logic [7:0] flag_choice(input int idx);
    case (idx)
      0:  return FLAG_SYN;
      1:  return FLAG_SYN | FLAG_ACK;
      2:  return FLAG_FIN;
      3:  return FLAG_FIN | FLAG_ACK;
      4:  return FLAG_FIN | FLAG_ACK | FLAG_PSH;
      5:  return FLAG_ACK;
      6:  return FLAG_ACK | FLAG_PSH;
      7:  return FLAG_RST;
      8:  return FLAG_RST | FLAG_ACK;
      9:  return FLAG_RST | FLAG_ACK | FLAG_FIN;
      10: return FLAG_RST | FLAG_ACK | FLAG_PSH;
      11: return FLAG_ECE | FLAG_ACK;
      12: return FLAG_CWR | FLAG_ACK;
      13: return FLAG_URG | FLAG_ACK;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_directed();
    // Segments too short to hold a header.
    seg_q.delete();
    seg_q.push_back(8'hA5);
    send_segment(1'b1);
    start_segment(4'd5, FLAG_SYN, 16'h0000, -1);
    truncate_segment(HDR_MIN_BYTES - 1);
    send_segment(1'b1);
    // Data offsets below the fixed header.
    start_segment(4'd0, FLAG_ACK, 16'h0000, -1);
    send_segment(1'b1);
    start_segment(4'd4, FLAG_ACK, 16'h0000, -1);
    add_payload(3);
    send_segment(1'b1);
    // A 60-byte header in a 40-byte segment.
    start_segment(4'd15, FLAG_ACK, 16'h0000, -1);
    add_payload(20);
    send_segment(1'b1);
    // Urgent data hides the unknown option behind it.
    start_segment(4'd6, FLAG_URG | FLAG_ACK, 16'h0001, -1);
    add_opt(8'hFE, 4);
    send_segment(1'b1);
    start_segment(4'd5, FLAG_URG | FLAG_ACK, 16'h0000, -1);
    add_payload(2);
    send_segment(1'b1);
    // All-ones header fields with every known option in a 60-byte header.
    start_segment(4'd15, FLAG_SYN | FLAG_ACK, 16'hFFFF, 255);
    seg_q.push_back(TAG_NOP);
    add_opt(TAG_MSS, LEN_MSS);
    add_opt(TAG_WSCALE, LEN_WSCALE);
    add_opt(TAG_SACKOK, LEN_SACKOK);
    add_opt(TAG_TSTAMP, LEN_TSTAMP);
    add_opt(TAG_SACK, 2 + SACK_BLOCK);
    seg_q.push_back(TAG_NOP);
    seg_q.push_back(TAG_END);
    add_payload(8 + 5);
    send_segment(1'b1);
    start_segment(4'd5, 8'h00, 16'h0000, 0);
    send_segment(1'b1);
    // End tag first: the rest of the option area is ignored.
    start_segment(4'd7, FLAG_ACK, 16'h0000, -1);
    seg_q.push_back(TAG_END);
    add_payload(7 + 4);
    send_segment(1'b1);
    // A tag on the final header byte.
    start_segment(4'd6, FLAG_ACK, 16'h0000, -1);
    repeat (3) seg_q.push_back(TAG_NOP);
    seg_q.push_back(TAG_MSS);
    send_segment(1'b1);
    // Length byte below two.
    start_segment(4'd6, FLAG_ACK, 16'h0000, -1);
    add_opt(TAG_WSCALE, 1);
    add_payload(2);
    send_segment(1'b1);
    // Option body running past the header.
    start_segment(4'd6, FLAG_ACK, 16'h0000, -1);
    seg_q.push_back(TAG_TSTAMP);
    seg_q.push_back(8'(LEN_TSTAMP));
    add_payload(2);
    send_segment(1'b1);
    // Wrong MSS length, then an unknown tag: the first problem is kept.
    start_segment(4'd7, FLAG_ACK, 16'h0000, -1);
    add_opt(TAG_MSS, 3);
    add_opt(8'd9, 2);
    repeat (3) seg_q.push_back(TAG_NOP);
    add_payload(1);
    send_segment(1'b1);
    start_segment(4'd6, FLAG_ACK, 16'h0000, -1);
    add_opt(TAG_SACKOK, 4);
    send_segment(1'b1);
    // Unknown tag, then an overrun: the unknown tag stays reported.
    start_segment(4'd6, FLAG_ACK, 16'h0000, -1);
    add_opt(8'hFF, 2);
    seg_q.push_back(TAG_NOP);
    seg_q.push_back(TAG_MSS);
    send_segment(1'b1);
    // Each of the flag choices, alternating with and without payload.
    for (int i = 0; i < FLAG_SETS; i++) begin
      start_segment(4'd5, flag_choice(i), 16'h0000, -1);
      add_payload((i % 2 != 0) ? $urandom_range(1, 6) : 0);
      send_segment(1'b1);
    end
  endtask

  task automatic run_random();
    int          sel;
    int          offw;
    logic [7:0]  flags;
    logic [15:0] urg;
    while (random_bytes < RANDOM_BYTES) begin
      if (!hold_req && random_bytes > 400) hold_req = 1'b1;
      sel   = $urandom_range(0, 99);
      flags = flag_choice($urandom_range(0, FLAG_SETS - 1));
      urg   = ((flags & FLAG_URG) != 0 && $urandom_range(0, 2) != 0) ? 16'h0000
                                                                   : 16'($urandom);
      offw  = $urandom_range(5, 15);
      if (sel < 70) begin
        start_segment(4'(offw), flags, urg, -1);
        fill_options(offw * 4 - HDR_MIN_BYTES, 1'b0);
        add_payload(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24));
      end else if (sel < 80) begin
        start_segment(4'(offw), flags, urg, -1);
        fill_options(offw * 4 - HDR_MIN_BYTES, 1'b1);
        add_payload($urandom_range(0, 8));
      end else if (sel < 85) begin
        start_segment(4'(offw), flags, urg, -1);
        truncate_segment($urandom_range(1, HDR_MIN_BYTES - 1));
      end else if (sel < 90) begin
        start_segment(4'($urandom_range(0, 4)), flags, urg, -1);
        add_payload($urandom_range(0, 12));
      end else if (sel < 95) begin
        offw = $urandom_range(6, 15);
        start_segment(4'(offw), flags, urg, -1);
        fill_options(offw * 4 - HDR_MIN_BYTES, 1'b1);
        truncate_segment($urandom_range(HDR_MIN_BYTES, offw * 4 - 1));
      end else begin
        seg_q.delete();
        add_payload($urandom_range(1, 60));
      end
      random_bytes += seg_q.size();
      send_segment(1'b1);
    end
  endtask

  // The receiver switches between popping patterns, with one long hold-off.
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    wait (rst_n);
    forever begin
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_pop <= 1'b0;
        repeat (800) @(posedge clk);
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_pop <= 1'b1;
          1: out_pop <= ($urandom_range(0, 3) != 0);
          2: out_pop <= ($urandom_range(0, 3) == 0);
          default: out_pop <= (tick % 4 == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_push <= 1'b0;
    while (pending_results != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("PASS tcp_header_option_checker");
    end else begin
      if (pending_results != 0) $display("%0d result words never arrived", pending_results);
      $display("FAIL tcp_header_option_checker");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("FAIL tcp_header_option_checker");
    $finish;
  end

endmodule

@@ tcp_header_option_checker.f @@
design/tcphc_pkg.sv
design/tcphc_front.sv
design/tcphc_seg_queue.sv
design/tcphc_back.sv
design/tcp_header_option_checker.sv
bench/tcp_result_checker.sv
bench/tb_top.sv
